// ===== hw/rtl/pfd_pkg.sv =====
// Package for the padded frame deframer: register map, reset values and field widths.
// No dependencies.
`default_nettype none

package pfd_pkg;

  localparam int unsigned LenW    = 16;  // payload length field
  localparam int unsigned PadW    = 8;   // padding length field
  localparam int unsigned CountW  = 8;   // frame counter and frames_to_strip
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [CountW-1:0] FramesToStripReset = 8'd8;

  // register indexes (byte address = 4 * index)
  typedef enum logic {
    REG_PADDING_ENABLED = 1'b0,
    REG_FRAMES_TO_STRIP = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic              byte_valid;
    logic [ByteW-1:0]  out_byte;
    logic              end_ok;
    logic              frame_error;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/padded_frame_deframer.sv =====
// Top level of the padded frame deframer: header parser, payload forwarding,
// padding drop, passthrough, and the APB register file. Depends on pfd_pkg.
`default_nettype none

// Each result is registered: in the result register, or in the skid while stalled.
// Throughput: one input beat per cycle while the skid register is empty; the
//   per-beat parser update is at most a 16-bit decrement and compare, between the
//   state and result registers. A two-entry output (result plus skid register) lets
//   input beats keep flowing after the consumer stalls, until the skid fills.
// Reset (rst, synchronous, active high): parser returns to header byte zero,
//   counters clear, padding_enabled = 0, frames_to_strip = 8, output empties.
module padded_frame_deframer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input beat channel
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire logic                          has_byte,
  input  wire logic [pfd_pkg::ByteW-1:0]     data_byte,
  input  wire logic                          end_of_stream,
  // result channel
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic                               byte_valid,
  output logic [pfd_pkg::ByteW-1:0]          out_byte,
  output logic                               end_ok,
  output logic                               frame_error,
  // APB configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pfd_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [pfd_pkg::ApbDataW-1:0]  pwdata,
  output logic [pfd_pkg::ApbDataW-1:0]       prdata,
  output logic                               pready
);
  import pfd_pkg::*;

  typedef enum logic [2:0] {
    PH_H0   = 3'd0,   // payload length, high byte
    PH_H1   = 3'd1,   // payload length, low byte
    PH_H2   = 3'd2,   // padding length
    PH_PAY  = 3'd3,   // forward payload
    PH_DISC = 3'd4    // drop padding
  } phase_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic              padding_enabled;
  logic [CountW-1:0] frames_to_strip;
  logic              cfg_write;
  reg_idx_t          cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_sel   = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      padding_enabled <= 1'b0;
      frames_to_strip <= FramesToStripReset;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_PADDING_ENABLED: padding_enabled <= pwdata[0];
        REG_FRAMES_TO_STRIP: frames_to_strip <= pwdata[CountW-1:0];
        default:             ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      REG_PADDING_ENABLED: prdata[0]        = padding_enabled;
      REG_FRAMES_TO_STRIP: prdata[CountW-1:0] = frames_to_strip;
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  phase_t            phase, phase_next;
  logic [LenW-1:0]   payload_left, payload_left_next;
  logic [PadW-1:0]   padding_left, padding_left_next;
  logic [CountW-1:0] frames_done, frames_done_next;
  result_t           res_next;
  logic              produce;
  logic              item_fire;

  logic              stripping;
  logic              stripping_end;
  logic              mid_frame;
  logic [LenW-1:0]   payload_dec;

  assign item_fire   = item_valid & item_ready;
  assign stripping   = padding_enabled & (frames_done < frames_to_strip);
  assign payload_dec = payload_left - LenW'(1);

  always_comb begin
    phase_next        = phase;
    payload_left_next = payload_left;
    padding_left_next = padding_left;
    frames_done_next  = frames_done;
    res_next          = '0;

    // Byte part of the beat
    if (has_byte) begin
      if (!stripping) begin
        res_next.byte_valid = 1'b1;
        res_next.out_byte   = data_byte;
      end else begin
        unique case (phase)
          PH_H1: begin
            payload_left_next = payload_left | LenW'(data_byte);
            phase_next        = PH_H2;
          end
          PH_H2: begin
            padding_left_next = data_byte;
            if (payload_left != '0) begin
              phase_next = PH_PAY;
            end else if (data_byte != '0) begin
              phase_next = PH_DISC;
            end else begin
              // empty frame still counts
              frames_done_next = frames_done + CountW'(1);
              phase_next       = PH_H0;
            end
          end
          PH_PAY: begin
            res_next.byte_valid = 1'b1;
            res_next.out_byte   = data_byte;
            payload_left_next   = payload_dec;
            if (payload_dec == '0) begin
              if (padding_left != '0) begin
                phase_next = PH_DISC;
              end else begin
                frames_done_next = frames_done + CountW'(1);
                phase_next       = PH_H0;
              end
            end
          end
          PH_DISC: begin
            padding_left_next = padding_left - PadW'(1);
            if (padding_left == PadW'(1)) begin
              frames_done_next = frames_done + CountW'(1);
              phase_next       = PH_H0;
            end
          end
          default: begin
            // header byte zero; unused codes land here too
            payload_left_next = {data_byte, {(LenW-ByteW){1'b0}}};
            phase_next        = PH_H1;
          end
        endcase
      end
    end

    // End mark, judged on the state left by the byte
    stripping_end = padding_enabled & (frames_done_next < frames_to_strip);
    mid_frame     = (phase_next != PH_H0) | (payload_left_next != '0) |
                    (padding_left_next != '0);
    if (end_of_stream) begin
      if (stripping_end && mid_frame) begin
        res_next.frame_error = 1'b1;
        phase_next           = PH_H0;
        payload_left_next    = '0;
        padding_left_next    = '0;
      end else begin
        res_next.end_ok = 1'b1;
      end
    end

    produce = res_next.byte_valid | end_of_stream;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_H0;
      payload_left <= '0;
      padding_left <= '0;
      frames_done  <= '0;
    end else if (item_fire) begin
      phase        <= phase_next;
      payload_left <= payload_left_next;
      padding_left <= padding_left_next;
      frames_done  <= frames_done_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with skid stage
  // ---------------------------------------------------------------------------
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;
  logic    out_free;
  logic    new_result;

  assign item_ready = ~skid_valid;
  assign out_free   = ~result_valid | result_ready;
  assign new_result = item_fire & produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        // drain skid first, park the new beat behind it
        result_valid <= 1'b1;
        skid_valid   <= new_result;
      end else begin
        result_valid <= new_result;
      end
    end else if (new_result) begin
      // output stalled: hold it, catch the new beat in the skid
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
        if (new_result) begin
          skid_reg <= res_next;
        end
      end else if (new_result) begin
        out_reg <= res_next;
      end
    end else if (new_result) begin
      skid_reg <= res_next;
    end
  end

  assign byte_valid  = out_reg.byte_valid;
  assign out_byte    = out_reg.out_byte;
  assign end_ok      = out_reg.end_ok;
  assign frame_error = out_reg.frame_error;

endmodule

`default_nettype wire
